### rtl/tet_mesh_shared_vertex_adjacency_core_macros.svh
// Assertion macros for the shared-vertex adjacency core
`ifndef TET_MESH_SHARED_VERTEX_ADJACENCY_CORE_MACROS_SVH
`define TET_MESH_SHARED_VERTEX_ADJACENCY_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every edge out of reset
`define TMSVA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be seen out of reset
`define TMSVA_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define TMSVA_ASSERT(name, prop, msg)
`define TMSVA_NEVER(name, cond, msg)

`endif

`endif

### rtl/tmsva_pkg.sv
// Shared types and constants for the shared-vertex adjacency core
package tmsva_pkg;

  localparam int LABEL_W = 24;
  localparam int VTX_W   = 24;
  localparam int CNT_W   = 6;
  localparam int EDGE_W  = 11;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [EDGE_W-1:0] EDGE_MAX  = '1;

  // item classification
  typedef enum logic {
    OP_ADD,
    OP_CLEAR
  } op_t;

  // back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SINGLE
  } st_t;

  // classified item as queued between front and back
  typedef struct packed {
    op_t                        op;
    logic [LABEL_W-1:0]         newer;
    logic [3:0][VTX_W-1:0]      corner;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic                       has_edge;
    logic [LABEL_W-1:0]         earlier_label;
    logic [LABEL_W-1:0]         newer_label;
    logic [CNT_W-1:0]           max_neighbors;
    logic [EDGE_W-1:0]          edge_total;
    logic                       table_full;
    logic                       last;
  } res_t;

endpackage

### rtl/tmsva_ram.sv
// Generic single write port RAM with registered read
module tmsva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tmsva_front.sv
// Front end: accepts input items, classifies them and queues them for the back end
module tmsva_front #(
  parameter int VERTEX_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [tmsva_pkg::LABEL_W-1:0] in_label,
  input  logic [tmsva_pkg::VTX_W-1:0]  in_corner_a,
  input  logic [tmsva_pkg::VTX_W-1:0]  in_corner_b,
  input  logic [tmsva_pkg::VTX_W-1:0]  in_corner_c,
  input  logic [tmsva_pkg::VTX_W-1:0]  in_corner_d,
  output logic                         q_valid,
  output tmsva_pkg::cmd_t              q_cmd,
  input  logic                         q_pop
);
  import tmsva_pkg::*;

  // vertex ids compare on their low VERTEX_BITS bits only
  localparam logic [VTX_W-1:0] VMASK =
    (VERTEX_BITS >= VTX_W) ? {VTX_W{1'b1}} : VTX_W'((64'(1) << VERTEX_BITS) - 64'(1));

  cmd_t               q_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  cmd_t               cls;
  logic               push;
  logic               pop;

  // classify the incoming item
  always_comb begin
    cls.op        = in_kind ? OP_CLEAR : OP_ADD;
    cls.newer     = in_label + LABEL_W'(1);
    cls.corner[0] = in_corner_a & VMASK;
    cls.corner[1] = in_corner_b & VMASK;
    cls.corner[2] = in_corner_c & VMASK;
    cls.corner[3] = in_corner_d & VMASK;
  end

  assign in_stall = (cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = q_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### rtl/tmsva_back.sv
// Back end: scans the element table, emits edges and keeps the running counters
module tmsva_back #(
  parameter int DEPTH       = 64,
  parameter int VERTEX_BITS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  tmsva_pkg::cmd_t q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output tmsva_pkg::res_t out_res
);
  import tmsva_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int VW     = (VERTEX_BITS < VTX_W) ? VERTEX_BITS : VTX_W;
  localparam int VRAM_W = 4 * VW;

  st_t               state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CNT_W-1:0]  max_r, max_nxt;
  logic [EDGE_W-1:0] edge_r, edge_nxt;
  logic [CW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  res_t              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r, out_nxt;

  logic              tbl_we;
  logic [VRAM_W-1:0] vtx_wdata;
  logic [VRAM_W-1:0] vtx_rdata;
  logic [LABEL_W-1:0] lbl_rdata;
  logic              cnt_we;
  logic [AW-1:0]     cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [CNT_W-1:0]  cnt_rdata;

  logic [3:0][VW-1:0] sv;
  logic              match;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  max_upd;
  logic [EDGE_W-1:0] edge_inc;
  logic              out_load_ok;
  logic              advance;
  logic              issue;
  logic              scan_done;

  // table storage
  assign vtx_wdata = {cmd_r.corner[3][VW-1:0], cmd_r.corner[2][VW-1:0],
                      cmd_r.corner[1][VW-1:0], cmd_r.corner[0][VW-1:0]};

  tmsva_ram #(.WIDTH(VRAM_W), .DEPTH(DEPTH)) u_vtx_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (vtx_wdata),
    .re    (issue),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (vtx_rdata)
  );

  tmsva_ram #(.WIDTH(LABEL_W), .DEPTH(DEPTH)) u_lbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (cmd_r.newer),
    .re    (issue),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (lbl_rdata)
  );

  tmsva_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (issue),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (cnt_rdata)
  );

  // 4x4 vertex compare against the entry held in the registered read data
  assign sv = vtx_rdata;
  always_comb begin
    match = 1'b0;
    for (int p = 0; p < 4; p++) begin
      for (int q = 0; q < 4; q++) begin
        if (sv[p] == cmd_r.corner[q][VW-1:0]) begin
          match = 1'b1;
        end
      end
    end
    match = match && cmp_valid_r;
  end

  // saturating counter updates
  assign cnt_inc  = (cnt_rdata != COUNT_MAX) ? cnt_rdata + CNT_W'(1) : cnt_rdata;
  assign max_upd  = (cnt_inc > max_r) ? cnt_inc : max_r;
  assign edge_inc = (edge_r != EDGE_MAX) ? edge_r + EDGE_W'(1) : edge_r;

  // scan flow control
  assign out_load_ok = !out_valid_r || !out_stall;
  assign advance     = !(match && pend_valid_r && !out_load_ok);
  assign issue       = (state_r == ST_SCAN) && advance && (rd_cnt_r < fill_r);
  assign scan_done   = (state_r == ST_SCAN) && (rd_cnt_r == fill_r) && !cmp_valid_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    fill_nxt       = fill_r;
    max_nxt        = max_r;
    edge_nxt       = edge_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_valid_nxt  = cmp_valid_r;
    cmp_idx_nxt    = cmp_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    q_pop          = 1'b0;
    tbl_we         = 1'b0;
    cnt_we         = 1'b0;
    cnt_waddr      = cmp_idx_r;
    cnt_wdata      = cnt_inc;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_cmd;
          rd_cnt_nxt     = '0;
          cmp_valid_nxt  = 1'b0;
          pend_valid_nxt = 1'b0;
          if (q_cmd.op == OP_CLEAR || fill_r == CW'(DEPTH)) begin
            state_nxt = ST_SINGLE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      // clear or dropped element: one result
      ST_SINGLE: begin
        if (out_load_ok) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.last  = 1'b1;
          if (cmd_r.op == OP_ADD) begin
            out_nxt.newer_label   = cmd_r.newer;
            out_nxt.table_full    = 1'b1;
            out_nxt.max_neighbors = max_r;
            out_nxt.edge_total    = edge_r;
          end else begin
            fill_nxt = '0;
            max_nxt  = '0;
            edge_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // one entry compared per cycle unless a match waits on a stalled output; the newest match waits in pend
        if (advance) begin
          cmp_valid_nxt = issue;
          if (issue) begin
            cmp_idx_nxt = rd_cnt_r[AW-1:0];
            rd_cnt_nxt  = rd_cnt_r + CW'(1);
          end
        end
        if (match && advance) begin
          cnt_we   = 1'b1;
          max_nxt  = max_upd;
          edge_nxt = edge_inc;
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = pend_r;
          end
          pend_valid_nxt         = 1'b1;
          pend_nxt.has_edge      = 1'b1;
          pend_nxt.earlier_label = lbl_rdata;
          pend_nxt.newer_label   = cmd_r.newer;
          pend_nxt.max_neighbors = max_upd;
          pend_nxt.edge_total    = edge_inc;
          pend_nxt.table_full    = 1'b0;
          pend_nxt.last          = 1'b0;
        end
        // end of scan: final result and append the element
        if (scan_done && out_load_ok) begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
          end else begin
            out_nxt               = '0;
            out_nxt.newer_label   = cmd_r.newer;
            out_nxt.max_neighbors = max_r;
            out_nxt.edge_total    = edge_r;
            out_nxt.last          = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          tbl_we         = 1'b1;
          cnt_we         = 1'b1;
          cnt_waddr      = fill_r[AW-1:0];
          cnt_wdata      = '0;
          fill_nxt       = fill_r + CW'(1);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      max_r        <= '0;
      edge_r       <= '0;
      rd_cnt_r     <= '0;
      cmp_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      max_r        <= max_nxt;
      edge_r       <= edge_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      cmp_valid_r  <= cmp_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

### rtl/tet_mesh_shared_vertex_adjacency_core.sv
// Top level of the shared-vertex adjacency core (tetrahedral dual graph edges).
// An item passes through the input queue to the back end; on an add the back end reads the
// stored entries of the table memories one entry per cycle unless a match waits on a stalled
// output; a clear or a dropped element gives a single result. Matches leave one per cycle unless the output stalls.
// Reset (synchronous, rst_n low) empties the queue and zeroes fill count and counters;
// the table memories are not cleared, since only entries below the fill count are read.
`include "tet_mesh_shared_vertex_adjacency_core_macros.svh"

module tet_mesh_shared_vertex_adjacency_core #(
  parameter int DEPTH       = 64,
  parameter int VERTEX_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [tmsva_pkg::LABEL_W-1:0] in_label,
  input  logic [tmsva_pkg::VTX_W-1:0]   in_corner_a,
  input  logic [tmsva_pkg::VTX_W-1:0]   in_corner_b,
  input  logic [tmsva_pkg::VTX_W-1:0]   in_corner_c,
  input  logic [tmsva_pkg::VTX_W-1:0]   in_corner_d,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_has_edge,
  output logic [tmsva_pkg::LABEL_W-1:0] out_earlier_label,
  output logic [tmsva_pkg::LABEL_W-1:0] out_newer_label,
  output logic [tmsva_pkg::CNT_W-1:0]   out_max_neighbors,
  output logic [tmsva_pkg::EDGE_W-1:0]  out_edge_total,
  output logic                          out_table_full,
  output logic                          out_last
);
  import tmsva_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  res_t res;

  tmsva_front #(.VERTEX_BITS(VERTEX_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_label    (in_label),
    .in_corner_a (in_corner_a),
    .in_corner_b (in_corner_b),
    .in_corner_c (in_corner_c),
    .in_corner_d (in_corner_d),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  tmsva_back #(.DEPTH(DEPTH), .VERTEX_BITS(VERTEX_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_has_edge      = res.has_edge;
  assign out_earlier_label = res.earlier_label;
  assign out_newer_label   = res.newer_label;
  assign out_max_neighbors = res.max_neighbors;
  assign out_edge_total    = res.edge_total;
  assign out_table_full    = res.table_full;
  assign out_last          = res.last;

  // result consistency
  `TMSVA_ASSERT(a_full_is_single, out_valid && out_table_full |-> out_last && !out_has_edge, "dropped element result must be a lone final result")
  `TMSVA_ASSERT(a_no_edge_is_last, out_valid && !out_has_edge |-> out_last, "result without edge must close its item")
  `TMSVA_NEVER(a_edge_without_count, out_valid && out_has_edge && out_edge_total == '0, "edge transfer with zero edge total")
  `TMSVA_NEVER(a_max_without_edges, out_valid && out_max_neighbors != '0 && out_edge_total == '0, "neighbor maximum set with no edges counted")

endmodule

### tb/tet_mesh_shared_vertex_adjacency_core_test.sv
// Self-checking testbench for the tetrahedral shared-vertex adjacency core
`timescale 1ns / 100ps

module tet_mesh_shared_vertex_adjacency_core_test;
  import tmsva_pkg::*;

  localparam int TBL_DEPTH    = 64;
  localparam int RANDOM_ITEMS = 96;
  localparam int TAIL_CYCLES  = 100;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int REPORT_MAX   = 10;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic                in_kind     = 1'b0;
  logic [LABEL_W-1:0]  in_label    = '0;
  logic [VTX_W-1:0]    in_corner_a = '0;
  logic [VTX_W-1:0]    in_corner_b = '0;
  logic [VTX_W-1:0]    in_corner_c = '0;
  logic [VTX_W-1:0]    in_corner_d = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic                out_has_edge;
  logic [LABEL_W-1:0]  out_earlier_label;
  logic [LABEL_W-1:0]  out_newer_label;
  logic [CNT_W-1:0]    out_max_neighbors;
  logic [EDGE_W-1:0]   out_edge_total;
  logic                out_table_full;
  logic                out_last;

  // predicted element table and running counters
  logic [VTX_W-1:0]    tbl_corner [TBL_DEPTH][4];
  logic [LABEL_W-1:0]  tbl_label  [TBL_DEPTH];
  logic [CNT_W-1:0]    tbl_count  [TBL_DEPTH];
  int                  tbl_fill = 0;
  logic [CNT_W-1:0]    max_cnt  = '0;
  logic [EDGE_W-1:0]   edge_cnt = '0;
  res_t                edge_results_due [$];

  // run bookkeeping
  bit sender_quiet = 1'b0;
  bit sink_quiet   = 1'b0;
  int stall_left   = 0;
  int cycle_count  = 0;
  int mismatches   = 0;
  int items_sent   = 0;
  int clears_sent  = 0;
  int results_seen = 0;
  int edges_seen   = 0;
  int drops_seen   = 0;

  tet_mesh_shared_vertex_adjacency_core #(
    .DEPTH       (TBL_DEPTH),
    .VERTEX_BITS (VTX_W)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_label          (in_label),
    .in_corner_a       (in_corner_a),
    .in_corner_b       (in_corner_b),
    .in_corner_c       (in_corner_c),
    .in_corner_d       (in_corner_d),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_has_edge      (out_has_edge),
    .out_earlier_label (out_earlier_label),
    .out_newer_label   (out_newer_label),
    .out_max_neighbors (out_max_neighbors),
    .out_edge_total    (out_edge_total),
    .out_table_full    (out_table_full),
    .out_last          (out_last)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tet_mesh_shared_vertex_adjacency_core_test: done, errors");
      $finish;
    end
  end

  // append one result to the expected list
  function automatic void add_expected(input res_t r);
    edge_results_due.insert(edge_results_due.size(), r);
  endfunction

  // expected results of one accepted element or clear
  task automatic predict_element(input op_t op, input logic [LABEL_W-1:0] label,
                                 input logic [3:0][VTX_W-1:0] corner);
    res_t               held;
    bit                 have_held;
    bit                 hit;
    logic [LABEL_W-1:0] newer;
    have_held = 1'b0;
    held      = '0;
    if (op == OP_CLEAR) begin
      tbl_fill = 0;
      max_cnt  = '0;
      edge_cnt = '0;
      held.last = 1'b1;
      add_expected(held);
      return;
    end
    newer = label + LABEL_W'(1);
    // dropped: not stored, not compared
    if (tbl_fill >= TBL_DEPTH) begin
      held.newer_label   = newer;
      held.max_neighbors = max_cnt;
      held.edge_total    = edge_cnt;
      held.table_full    = 1'b1;
      held.last          = 1'b1;
      add_expected(held);
      return;
    end
    // scan stored entries in table order; hold back one so last can be set
    for (int i = 0; i < tbl_fill; i++) begin
      hit = 1'b0;
      for (int p = 0; p < 4; p++)
        for (int q = 0; q < 4; q++)
          if (tbl_corner[i][p] == corner[q]) hit = 1'b1;
      if (hit) begin
        if (tbl_count[i] != COUNT_MAX) tbl_count[i]++;
        if (tbl_count[i] > max_cnt) max_cnt = tbl_count[i];
        if (edge_cnt != EDGE_MAX) edge_cnt++;
        if (have_held) add_expected(held);
        held               = '0;
        held.has_edge      = 1'b1;
        held.earlier_label = tbl_label[i];
        held.newer_label   = newer;
        held.max_neighbors = max_cnt;
        held.edge_total    = edge_cnt;
        have_held          = 1'b1;
      end
    end
    for (int p = 0; p < 4; p++) tbl_corner[tbl_fill][p] = corner[p];
    tbl_label[tbl_fill] = newer;
    tbl_count[tbl_fill] = '0;
    tbl_fill++;
    // no neighbor: a single plain result
    if (!have_held) begin
      held.newer_label   = newer;
      held.max_neighbors = max_cnt;
      held.edge_total    = edge_cnt;
    end
    held.last = 1'b1;
    add_expected(held);
  endtask

  function automatic int pick_gap();
    int pick;
    if (sender_quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one input transfer; valid stays high so back-to-back items need no second NBA
  task automatic send_item(input op_t op, input logic [LABEL_W-1:0] label,
                           input logic [VTX_W-1:0] ca, cb, cc, cd);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= op;
    in_label    <= label;
    in_corner_a <= ca;
    in_corner_b <= cb;
    in_corner_c <= cc;
    in_corner_d <= cd;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_element(op, label, {cd, cc, cb, ca});
    items_sent++;
    if (op == OP_CLEAR) clears_sent++;
  endtask

  // hold off the sender until every expected result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (edge_results_due.size() != 0);
  endtask

  function automatic void check_field(input string fld, input logic [31:0] got,
                                      input logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch in %s, result %0d: expected %0h, got %0h",
                 fld, results_seen, want, got);
    end
  endfunction

  // result checker and random sink stalls
  always @(posedge clk) begin
    res_t want;
    int   pick;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (edge_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result %0d: newer %0h earlier %0h",
                   results_seen, out_newer_label, out_earlier_label);
      end else begin
        want = edge_results_due.pop_front();
        check_field("has_edge", 32'(out_has_edge), 32'(want.has_edge));
        check_field("earlier_label", 32'(out_earlier_label), 32'(want.earlier_label));
        check_field("newer_label", 32'(out_newer_label), 32'(want.newer_label));
        check_field("max_neighbors", 32'(out_max_neighbors), 32'(want.max_neighbors));
        check_field("edge_total", 32'(out_edge_total), 32'(want.edge_total));
        check_field("table_full", 32'(out_table_full), 32'(want.table_full));
        check_field("last", 32'(out_last), 32'(want.last));
      end
      results_seen++;
      if (out_has_edge === 1'b1) edges_seen++;
      if (out_table_full === 1'b1) drops_seen++;
    end
    // mostly short stalls, a few long ones
    if (stall_left != 0) begin
      stall_left--;
    end else if (!sink_quiet) begin
      pick = $urandom_range(0, 99);
      if (pick >= 95) stall_left = $urandom_range(10, 40);
      else if (pick >= 70) stall_left = $urandom_range(1, 3);
    end
    out_stall <= (stall_left != 0);
  end

  // extremes, wrap of the label, many corner pairings, duplicates, clear
  task automatic test_corner_cases();
    send_item(OP_CLEAR, '0, '0, '0, '0, '0);
    send_item(OP_ADD, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
    send_item(OP_ADD, 24'hFFFFFE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(OP_ADD, 24'hFFFFFF, 24'hFFFFFF, 24'h000001, 24'h000002, 24'h000003);
    send_item(OP_ADD, 24'h00000A, 24'h000004, 24'h000005, 24'h000006, 24'h000000);
    send_item(OP_ADD, 24'h00000B, 24'h000001, 24'h000007, 24'h000008, 24'h000009);
    send_item(OP_ADD, 24'h00000C, 24'hA5A5A5, 24'h5A5A5A, 24'h800000, 24'h000003);
    send_item(OP_ADD, 24'h00000D, 24'h000002, 24'h000002, 24'h000002, 24'h000002);
    send_item(OP_ADD, 24'hAAAAAA, 24'h000000, 24'h000001, 24'hFFFFFF, 24'h000009);
    send_item(OP_ADD, 24'h555555, 24'h123456, 24'h234567, 24'h345678, 24'h456789);
    send_item(OP_ADD, 24'h000010, 24'h7FFFFF, 24'h800000, 24'h5A5A5A, 24'h345678);
    drain_results();
    // table and counters restart after a clear
    send_item(OP_CLEAR, 24'hFFFFFE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(OP_ADD, 24'h000014, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
    send_item(OP_ADD, 24'h000015, 24'h000009, 24'h000009, 24'h000009, 24'h000000);
    send_item(OP_ADD, 24'h000016, 24'h000009, 24'hFFFFFF, 24'h000000, 24'h000000);
    send_item(OP_CLEAR, '0, '0, '0, '0, '0);
    drain_results();
  endtask

  // every element shares one vertex: counts reach 63, then the table is full
  task automatic test_table_overflow();
    sender_quiet = 1'b1;
    for (int k = 0; k < TBL_DEPTH; k++) begin
      if (k == TBL_DEPTH / 2) sender_quiet = 1'b0;
      send_item(OP_ADD, LABEL_W'(k), 24'h3C3C3C,
                VTX_W'($urandom), VTX_W'($urandom), VTX_W'($urandom));
    end
    send_item(OP_ADD, 24'h0000FF, 24'h3C3C3C,
              VTX_W'($urandom), VTX_W'($urandom), VTX_W'($urandom));
    send_item(OP_ADD, 24'hFFFFFE, VTX_W'($urandom),
              VTX_W'($urandom), VTX_W'($urandom), VTX_W'($urandom));
    drain_results();
    send_item(OP_CLEAR, LABEL_W'($urandom), VTX_W'($urandom),
              VTX_W'($urandom), VTX_W'($urandom), VTX_W'($urandom));
    send_item(OP_ADD, 24'h000001, 24'h3C3C3C, 24'h000000, 24'h000000, 24'h000000);
    drain_results();
  endtask

  // mostly small meshes over narrow vertex pools, some noise and clears
  task automatic test_random_meshes();
    int                 sent;
    int                 len;
    int                 pool;
    int                 pick;
    bit                 in_order;
    logic [VTX_W-1:0]   base;
    logic [LABEL_W-1:0] lbl;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick         = $urandom_range(0, 9);
      sender_quiet = ($urandom_range(0, 4) == 0);
      sink_quiet   = ($urandom_range(0, 4) == 0);
      if (pick == 0) begin
        send_item(OP_CLEAR, LABEL_W'($urandom), VTX_W'($urandom),
                  VTX_W'($urandom), VTX_W'($urandom), VTX_W'($urandom));
        sent++;
      end else if (pick == 1) begin
        send_item(OP_ADD, LABEL_W'($urandom_range(0, 24'hFFFFFE)),
                  VTX_W'($urandom), VTX_W'($urandom),
                  VTX_W'($urandom), VTX_W'($urandom));
        sent++;
      end else begin
        len      = $urandom_range(3, 12);
        pool     = $urandom_range(4, 48);
        base     = VTX_W'($urandom);
        lbl      = LABEL_W'($urandom_range(0, 24'hFFFFF0));
        in_order = $urandom_range(0, 1);
        repeat (len) begin
          send_item(OP_ADD, in_order ? lbl : LABEL_W'($urandom_range(0, 24'hFFFFFE)),
                    VTX_W'(base + $urandom_range(0, pool - 1)),
                    VTX_W'(base + $urandom_range(0, pool - 1)),
                    VTX_W'(base + $urandom_range(0, pool - 1)),
                    VTX_W'(base + $urandom_range(0, pool - 1)));
          lbl++;
          sent++;
        end
      end
      if ($urandom_range(0, 7) == 0) drain_results();
    end
    sender_quiet = 1'b0;
    sink_quiet   = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_cases();
    test_table_overflow();
    test_random_meshes();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d items (%0d clears) and %0d results",
             items_sent, clears_sent, results_seen);
    $display("%0d neighbor edges, %0d dropped elements, %0d mismatches",
             edges_seen, drops_seen, mismatches);
    if (mismatches == 0) begin
      $display("tet_mesh_shared_vertex_adjacency_core_test: done, clean");
    end else begin
      $display("tet_mesh_shared_vertex_adjacency_core_test: done, errors");
    end
    $finish;
  end

endmodule
